### rtl/tssrp_pkg.sv
// Shared types and constants for the three-slot sample recorder/player.
// No dependencies; imported by tssrp_store and the top level.
`default_nettype none

package tssrp_pkg;

  localparam int SLOT_DEPTH_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int NUM_SLOTS       = 3;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 7;
  localparam int ADC_W    = 12;
  localparam int DAC_W    = 10;
  localparam int CLIP_W   = 13;
  localparam int SLOT_W   = 2;

  localparam logic [CLIP_W-1:0] CLIP_LENGTH_RESET = 13'd4000;

  typedef enum logic [OP_W-1:0] {
    OP_KEY    = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  localparam logic [KEY_W-1:0] KEY_ONE   = 7'h31;
  localparam logic [KEY_W-1:0] KEY_TWO   = 7'h32;
  localparam logic [KEY_W-1:0] KEY_THREE = 7'h33;
  localparam logic [KEY_W-1:0] KEY_REC   = 7'h39;

  localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_ONE  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_TWO  = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_THREE = 2'd3;

  // LED bit order: red, green, blue
  localparam int LED_RED   = 0;
  localparam int LED_GREEN = 1;
  localparam int LED_BLUE  = 2;

  typedef logic [2:0] led_t;

  // One memory access per word
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [SLOT_W-1:0]  slot;   // 1..3
  } store_cmd_t;

  function automatic logic [SLOT_W-1:0] key_slot(input logic [KEY_W-1:0] k);
    logic [SLOT_W-1:0] s;
    s = SLOT_NONE;
    if (k == KEY_ONE)   s = SLOT_ONE;
    if (k == KEY_TWO)   s = SLOT_TWO;
    if (k == KEY_THREE) s = SLOT_THREE;
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/tssrp_store.sv
// Sample memory for three slots with per-slot fill counts.
// Depends on tssrp_pkg. One access per cycle, read data registered.
`default_nettype none

module tssrp_store #(
  parameter int SLOT_DEPTH  = tssrp_pkg::SLOT_DEPTH_DEF,
  parameter int SAMPLE_BITS = tssrp_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  tssrp_pkg::store_cmd_t              cmd,
  input  wire  [$clog2(SLOT_DEPTH)-1:0]      index,
  input  wire  [SAMPLE_BITS-1:0]             wdata,
  output logic [SAMPLE_BITS-1:0]             rdata,
  output logic                               rhit
);
  import tssrp_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DEPTH  = NUM_SLOTS * SLOT_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  // Entries at or above a slot's fill count were never written; reads of them return rhit low.
  logic [CNT_W-1:0]       fill [NUM_SLOTS];

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] addr;
  logic [1:0]        sidx;
  logic [CNT_W-1:0]  index_ext;

  always_comb begin
    unique case (cmd.slot)
      SLOT_TWO: begin
        base = ADDR_W'(SLOT_DEPTH);
        sidx = 2'd1;
      end
      SLOT_THREE: begin
        base = ADDR_W'(2 * SLOT_DEPTH);
        sidx = 2'd2;
      end
      default: begin
        base = '0;
        sidx = 2'd0;
      end
    endcase
    index_ext = CNT_W'(index);
    addr      = base + ADDR_W'(index);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        fill[i] <= '0;
      end
      rhit <= 1'b0;
    end else begin
      // writes run in order from entry 0, so the written set is a prefix
      if (cmd.wr && index_ext >= fill[sidx]) begin
        fill[sidx] <= index_ext + CNT_W'(1);
      end
      if (cmd.rd) begin
        rhit <= index_ext < fill[sidx];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/three_slot_sample_recorder_player_top.sv
// Three-slot clip recorder/player: control, result pipeline, config register.
// Depends on tssrp_pkg and tssrp_store.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one word per event: opcode
//    selects key press (key_char), ADC sample (sample_in) or playback tick.
//  - Every accepted word produces exactly one result word on the output
//    channel (out_valid/out_ready): DAC sample for ticks plus LED, record
//    and playback status after the event.
//  - Config channel (cfg_valid/cfg_ready/cfg_data) writes clip_length; always
//    ready. Write it only while no words are in flight.
//  - Result path: the memory read and the result stage load at the accepting
//    edge; the output register loads from them when the result stage advances.
//  - Throughput: one word per cycle while the output is not stalled. Control
//    state lives in flops and is updated in the accept cycle; the memory sees at
//    most one read or write per word, so consecutive words never contend for it.
//  - Stall: a result stage plus output register form a skid pair; with the
//    receiver stalled, one more word is accepted, then in_ready drops.
//  - Reset: control state cleared, clip_length back to 4000. The sample
//    memory is not swept; per-slot fill counts make unwritten entries read
//    as zero, so no memory clearing is needed before use.
`default_nettype none

module three_slot_sample_recorder_player_top #(
  parameter int SLOT_DEPTH  = tssrp_pkg::SLOT_DEPTH_DEF,
  parameter int SAMPLE_BITS = tssrp_pkg::SAMPLE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // config
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [tssrp_pkg::CLIP_W-1:0]      cfg_data,
  // input events
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [tssrp_pkg::OP_W-1:0]        opcode,
  input  wire  [tssrp_pkg::KEY_W-1:0]       key_char,
  input  wire  [tssrp_pkg::ADC_W-1:0]       sample_in,
  // results
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              dac_valid,
  output logic [tssrp_pkg::DAC_W-1:0]       dac_value,
  output logic                              led_red,
  output logic                              led_green,
  output logic                              led_blue,
  output logic                              record_armed,
  output logic                              play_busy
);
  import tssrp_pkg::*;

  localparam int IDX_W = $clog2(SLOT_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  // ---------------- config ----------------
  logic [CLIP_W-1:0] clip_length;
  logic [CNT_W-1:0]  eff_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_length <= CLIP_LENGTH_RESET;
    end else if (cfg_valid) begin
      clip_length <= cfg_data;
    end
  end

  // lengths beyond a slot clamp to the slot size
  assign eff_len = (32'(clip_length) > 32'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH)
                                                        : CNT_W'(clip_length);

  // ---------------- handshake ----------------
  logic s1_valid;
  logic s1_adv;
  logic accept;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // ---------------- control state ----------------
  logic              rec_mode,    rec_mode_next;
  logic [SLOT_W-1:0] rec_slot,    rec_slot_next;
  logic [CNT_W-1:0]  rec_count,   rec_count_next;
  logic              play_active, play_active_next;
  logic [SLOT_W-1:0] play_slot,   play_slot_next;
  logic [CNT_W-1:0]  play_index,  play_index_next;
  led_t              led_state,   led_state_next;
  logic              tick_hit;
  logic [SLOT_W-1:0] ks;

  store_cmd_t              cmd;
  logic [IDX_W-1:0]        mem_index;
  logic [SAMPLE_BITS-1:0]  mem_wdata;
  logic [SAMPLE_BITS-1:0]  mem_rdata;
  logic                    mem_rhit;

  always_comb begin
    rec_mode_next    = rec_mode;
    rec_slot_next    = rec_slot;
    rec_count_next   = rec_count;
    play_active_next = play_active;
    play_slot_next   = play_slot;
    play_index_next  = play_index;
    led_state_next   = led_state;
    tick_hit         = 1'b0;
    cmd              = '0;
    mem_index        = rec_count[IDX_W-1:0];
    mem_wdata        = SAMPLE_BITS'(sample_in);
    ks               = key_slot(key_char);

    unique case (opcode)
      OP_KEY: begin
        if (!rec_mode) begin
          if (ks != SLOT_NONE) begin
            // start or restart playback, only that slot's LED lit
            play_active_next = 1'b1;
            play_slot_next   = ks;
            play_index_next  = '0;
            led_state_next   = '0;
            unique case (ks)
              SLOT_ONE: led_state_next[LED_RED]   = 1'b1;
              SLOT_TWO: led_state_next[LED_GREEN] = 1'b1;
              default:  led_state_next[LED_BLUE]  = 1'b1;
            endcase
          end else if (key_char == KEY_REC) begin
            rec_mode_next   = 1'b1;
            rec_slot_next   = SLOT_NONE;
            rec_count_next  = '0;
            led_state_next[LED_RED]   = 1'b1;
            led_state_next[LED_GREEN] = 1'b1;
          end
        end else begin
          if (rec_slot == SLOT_NONE && ks != SLOT_NONE) begin
            rec_slot_next = ks;
          end
          if (key_char == KEY_REC) begin
            rec_mode_next  = 1'b0;
            led_state_next = '0;
          end
        end
      end
      OP_SAMPLE: begin
        if (rec_mode && rec_slot != SLOT_NONE) begin
          if (rec_count < eff_len) begin
            cmd.wr         = accept;
            cmd.slot       = rec_slot;
            rec_count_next = rec_count + CNT_W'(1);
          end
          // full clip (or length shrunk under the count) ends recording
          if (rec_count_next >= eff_len) begin
            rec_mode_next  = 1'b0;
            led_state_next = '0;
          end
        end
      end
      OP_TICK: begin
        if (play_active) begin
          mem_index = play_index[IDX_W-1:0];
          if (play_index < eff_len) begin
            tick_hit        = 1'b1;
            cmd.rd          = accept;
            cmd.slot        = play_slot;
            play_index_next = play_index + CNT_W'(1);
          end
          if (!tick_hit || play_index_next >= eff_len) begin
            play_active_next = 1'b0;
            led_state_next   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_mode    <= 1'b0;
      rec_slot    <= SLOT_NONE;
      rec_count   <= '0;
      play_active <= 1'b0;
      play_slot   <= SLOT_NONE;
      play_index  <= '0;
      led_state   <= '0;
    end else if (accept) begin
      rec_mode    <= rec_mode_next;
      rec_slot    <= rec_slot_next;
      rec_count   <= rec_count_next;
      play_active <= play_active_next;
      play_slot   <= play_slot_next;
      play_index  <= play_index_next;
      led_state   <= led_state_next;
    end
  end

  // ---------------- sample memory ----------------
  tssrp_store #(
    .SLOT_DEPTH  (SLOT_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .index (mem_index),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .rhit  (mem_rhit)
  );

  // ---------------- DAC code: top DAC_W bits of the sample ----------------
  logic [DAC_W-1:0] dac_code;

  if (SAMPLE_BITS >= DAC_W) begin : g_dac_shr
    assign dac_code = mem_rdata[SAMPLE_BITS-1 -: DAC_W];
  end else begin : g_dac_shl
    assign dac_code = {mem_rdata, {(DAC_W - SAMPLE_BITS){1'b0}}};
  end

  // ---------------- result stage (waits on memory read) ----------------
  logic s1_dac_valid;
  led_t s1_led;
  logic s1_rec;
  logic s1_play;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dac_valid <= tick_hit;
      s1_led       <= led_state_next;
      s1_rec       <= rec_mode_next;
      s1_play      <= play_active_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_adv || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dac_valid    <= s1_dac_valid;
      dac_value    <= (s1_dac_valid && mem_rhit) ? dac_code : '0;
      led_red      <= s1_led[LED_RED];
      led_green    <= s1_led[LED_GREEN];
      led_blue     <= s1_led[LED_BLUE];
      record_armed <= s1_rec;
      play_busy    <= s1_play;
    end
  end

  // ---------------- assertions ----------------
  a_rec_count_bound: assert property (@(posedge clk) disable iff (rst)
    rec_count <= CNT_W'(SLOT_DEPTH))
    else $error("rec_count past slot depth");

  a_play_slot_set: assert property (@(posedge clk) disable iff (rst)
    play_active |-> (play_slot != SLOT_NONE))
    else $error("playback active without a slot");

  a_play_index_bound: assert property (@(posedge clk) disable iff (rst)
    play_index <= CNT_W'(SLOT_DEPTH))
    else $error("play_index past slot depth");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr && cmd.rd))
    else $error("memory read and write in one cycle");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("result stage dropped a word under stall");

endmodule

`default_nettype wire
